[src/esc_pkg.sv]
// ----------------------------------------------------------------------------
// esc_pkg
// Shared types and constants of the e-mail address syntax checker: the input
// and result words, the configuration set, register indexes and error codes.
// ----------------------------------------------------------------------------
`default_nettype none

package esc_pkg;

	// One byte of the address and its end marker.
	typedef struct packed {
		logic [7:0] char_byte;
		logic       is_last;
	} in_word_t;

	// Verdict for one whole address.
	typedef struct packed {
		logic       address_ok;
		logic [3:0] error_code;
	} out_word_t;

	// Error codes, in the order of their numeric value.
	typedef enum logic [3:0] {
		ERR_NONE         = 4'd0,
		ERR_LENGTH       = 4'd1,
		ERR_FORM         = 4'd2,
		ERR_LOCAL_LONG   = 4'd3,
		ERR_LOCAL_EDGE   = 4'd4,
		ERR_LOCAL_CHAR   = 4'd5,
		ERR_EDGE_FOLLOW  = 4'd6,
		ERR_LABEL_SIZE   = 4'd7,
		ERR_LABEL_HYPHEN = 4'd8,
		ERR_DOMAIN_CHAR  = 4'd9,
		ERR_FEW_LABELS   = 4'd10
	} err_code_t;

	// Configuration register file.
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 8;

	localparam logic [CFG_IDX_W-1:0] REG_MAX_TOTAL_LEN = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LOCAL_LEN = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_LABEL_LEN = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MIN_LABELS    = 2'd3;

	localparam logic [7:0] RST_MAX_TOTAL_LEN = 8'd254;
	localparam logic [7:0] RST_MAX_LOCAL_LEN = 8'd64;
	localparam logic [7:0] RST_MAX_LABEL_LEN = 8'd63;
	localparam logic [3:0] RST_MIN_LABELS    = 4'd2;

	typedef struct packed {
		logic [7:0] max_total_len;
		logic [7:0] max_local_len;
		logic [7:0] max_label_len;
		logic [3:0] min_labels;
	} cfg_t;

	// Characters with a role in the syntax.
	localparam logic [7:0] CHAR_AT     = 8'h40;
	localparam logic [7:0] CHAR_DOT    = 8'h2E;
	localparam logic [7:0] CHAR_HYPHEN = 8'h2D;

endpackage

`default_nettype wire

[src/esc_cfg_regs.sv]
// ----------------------------------------------------------------------------
// esc_cfg_regs
// Configuration registers of the checker, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_cfg_regs
	import esc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data,
	output cfg_t                       cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_total_len <= RST_MAX_TOTAL_LEN;
			cfg_q.max_local_len <= RST_MAX_LOCAL_LEN;
			cfg_q.max_label_len <= RST_MAX_LABEL_LEN;
			cfg_q.min_labels    <= RST_MIN_LABELS;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_MAX_TOTAL_LEN: cfg_q.max_total_len <= cfg_data;
				REG_MAX_LOCAL_LEN: cfg_q.max_local_len <= cfg_data;
				REG_MAX_LABEL_LEN: cfg_q.max_label_len <= cfg_data;
				REG_MIN_LABELS:    cfg_q.min_labels    <= cfg_data[3:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

[src/esc_scan.sv]
// ----------------------------------------------------------------------------
// esc_scan
// Per-address scan state and its update. Each step consumes one
// byte; on the final byte the verdict is formed and the state clears.
// ----------------------------------------------------------------------------
`default_nettype none

module esc_scan
	import esc_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     step,
	input  wire in_word_t in_word,
	input  wire cfg_t     cfg,
	output out_word_t     result
);

	typedef struct packed {
		logic [7:0] total_count;
		logic       total_over;
		logic       seen_at;
		logic [7:0] local_count;
		logic       local_first_edge;
		logic [7:0] prev_byte;
		err_code_t  local_error;
		err_code_t  domain_error;
		logic [7:0] label_length;
		logic       label_first_hyphen;
		logic       label_bad_char;
		logic [7:0] label_total;
	} scan_state_t;

	scan_state_t st_q;
	scan_state_t nx;

	function automatic logic is_alnum(input logic [7:0] c);
		return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		       (c >= 8'h61 && c <= 8'h7A);
	endfunction

	function automatic logic is_edge(input logic [7:0] c);
		return (c == CHAR_DOT) || (c == CHAR_HYPHEN);
	endfunction

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	logic [7:0] c;
	logic       at_now;
	logic       close_en;
	logic [7:0] close_char;
	err_code_t  close_err;
	err_code_t  code;

	always_comb begin
		c          = in_word.char_byte;
		nx         = st_q;
		at_now     = 1'b0;
		close_err  = ERR_NONE;
		code       = ERR_NONE;

		if (st_q.total_count == 8'hFF) begin
			nx.total_over = 1'b1;
		end else begin
			nx.total_count = st_q.total_count + 8'd1;
		end

		if (!st_q.seen_at) begin
			if (c == CHAR_AT) begin
				nx.seen_at = 1'b1;
				at_now     = 1'b1;
				if (st_q.local_count != 8'd0 && is_edge(st_q.prev_byte)) begin
					nx.local_first_edge = 1'b1;
				end
			end else begin
				if (st_q.local_count == 8'd0) begin
					if (is_edge(c)) begin
						nx.local_first_edge = 1'b1;
					end
				end else if (is_edge(st_q.prev_byte) && !is_alnum(c) &&
				             st_q.local_error == ERR_NONE) begin
					nx.local_error = ERR_EDGE_FOLLOW;
				end
				if (!is_alnum(c) && !is_edge(c) && nx.local_error == ERR_NONE) begin
					nx.local_error = ERR_LOCAL_CHAR;
				end
				nx.local_count = sat_inc(st_q.local_count);
			end
		end else if (c != CHAR_DOT) begin
			if (st_q.label_length == 8'd0) begin
				nx.label_first_hyphen = (c == CHAR_HYPHEN);
			end
			if (!is_alnum(c) && c != CHAR_HYPHEN) begin
				nx.label_bad_char = 1'b1;
			end
			nx.label_length = sat_inc(st_q.label_length);
		end
		nx.prev_byte = c;

		// A label closes on a dot, or at the end of the address unless the
		// address ends in a dot (that dot already closed it).
		close_en   = st_q.seen_at && ((c == CHAR_DOT) || in_word.is_last);
		close_char = (c == CHAR_DOT) ? st_q.prev_byte : c;
		if (nx.label_length == 8'd0 || nx.label_length > cfg.max_label_len) begin
			close_err = ERR_LABEL_SIZE;
		end else if (nx.label_first_hyphen || close_char == CHAR_HYPHEN) begin
			close_err = ERR_LABEL_HYPHEN;
		end else if (nx.label_bad_char) begin
			close_err = ERR_DOMAIN_CHAR;
		end
		if (close_en) begin
			if (st_q.domain_error == ERR_NONE) begin
				nx.domain_error = close_err;
			end
			nx.label_total        = sat_inc(st_q.label_total);
			nx.label_length       = 8'd0;
			nx.label_first_hyphen = 1'b0;
			nx.label_bad_char     = 1'b0;
		end

		if (nx.total_over || nx.total_count > cfg.max_total_len) begin
			code = ERR_LENGTH;
		end else if (!nx.seen_at || nx.local_count == 8'd0 || at_now) begin
			code = ERR_FORM;
		end else if (nx.local_count > cfg.max_local_len) begin
			code = ERR_LOCAL_LONG;
		end else if (nx.local_first_edge) begin
			code = ERR_LOCAL_EDGE;
		end else if (nx.local_error != ERR_NONE) begin
			code = nx.local_error;
		end else if (nx.domain_error != ERR_NONE) begin
			code = nx.domain_error;
		end else if (nx.label_total < {4'd0, cfg.min_labels}) begin
			code = ERR_FEW_LABELS;
		end

		result.address_ok = (code == ERR_NONE);
		result.error_code = code;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= '0;
		end else if (step) begin
			st_q <= in_word.is_last ? scan_state_t'('0) : nx;
		end
	end

endmodule

`default_nettype wire

[src/email_syntax_checker_unit.sv]
// ----------------------------------------------------------------------------
// email_syntax_checker_unit
// Byte-serial syntax check of an e-mail address with a pass/fail verdict and
// an error code delivered once per address, on its final byte.
// ----------------------------------------------------------------------------
//
//   Channel  | Direction | Handshake                 | Word
//   ---------+-----------+---------------------------+---------------------------
//   in       | input     | in_valid / in_ready       | in_word_t  (byte, last)
//   out      | output    | out_valid / out_ready     | out_word_t (ok, code)
//   cfg      | input     | cfg_wr_en (no back-press) | cfg_index, cfg_data
//
// One byte is accepted per cycle unless a final byte waits in the input
// register for a full output register. An accepted word sits in the input
// register while the scan logic updates the per-address state; when a final
// byte is consumed, its verdict is registered in the output register, which
// drives out_valid and holds the verdict until taken. The output register lets the scan keep
// consuming non-final bytes while a verdict waits; only a final byte waits in
// the input register for the output register to empty. Reset (arst_n low)
// empties both registers, clears the scan state and loads the register
// defaults.
//
`default_nettype none

module email_syntax_checker_unit
	import esc_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,

	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_word_t              in_data,

	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_word_t                  out_data,

	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_data
);

	cfg_t      cfg;
	in_word_t  in_word_s1;
	logic      valid_s1;
	out_word_t result;
	out_word_t out_word_q;
	logic      out_valid_q;
	logic      out_free;
	logic      step;

	esc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The output register can take a verdict when empty or being drained.
	assign out_free = !out_valid_q || out_ready;

	// A non-final byte always advances; a final byte needs room for its verdict.
	assign step     = valid_s1 && (!in_word_s1.is_last || out_free);
	assign in_ready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (step) begin
			valid_s1 <= 1'b0;
		end
	end

	// Payload register, loaded on acceptance only.
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_word_s1 <= in_data;
		end
	end

	esc_scan u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_word (in_word_s1),
		.cfg     (cfg),
		.result  (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (step && in_word_s1.is_last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step && in_word_s1.is_last) begin
			out_word_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

`ifndef SYNTHESIS
	// Every final byte that is consumed leaves a verdict behind.
	a_last_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		step && in_word_s1.is_last |=> out_valid_q)
		else $error("final byte consumed without a verdict");

	// A final byte blocked by a full output register is held, not dropped.
	a_last_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && in_word_s1.is_last && out_valid_q && !out_ready
		|=> valid_s1 && in_word_s1.is_last)
		else $error("blocked final byte was lost");

	// The pass flag agrees with the error code.
	a_ok_matches_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_word_q.address_ok == (out_word_q.error_code == ERR_NONE)))
		else $error("pass flag disagrees with error code");

	// Only defined error codes are reported.
	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (out_word_q.error_code <= ERR_FEW_LABELS))
		else $error("undefined error code reported");
`endif

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for email_syntax_checker_unit. Addresses are streamed in
// one byte per word. An independent scan of every accepted byte predicts the
// verdict of each address, and the verdicts coming out are checked against it
// in order. The run covers hand-picked addresses for each syntax rule, limit
// register corners, addresses long enough to saturate the counters, and
// random traffic under a series of register settings, with random stalls on
// both channels.
// ----------------------------------------------------------------------------

module testbench;
	import esc_pkg::*;

	localparam int CLK_PERIOD   = 4;
	localparam int RESET_CYCLES = 6;
	// A verdict passes the input and then the output register after its final
	// byte is accepted; the drain wait gives any trailing bytes time to leave the input register.
	localparam int DRAIN_CYCLES = 8;
	localparam int SETTLE_LIMIT = 4000;
	localparam int TIMEOUT_NS   = 4_000_000;
	localparam int RANDOM_WORDS = 420;
	localparam int IDLE_PERCENT = 38;
	localparam int MAX_PRINTS   = 100;

	localparam string ALNUM_SET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";

	localparam cfg_t DEFAULT_REGS = '{
		max_total_len: RST_MAX_TOTAL_LEN,
		max_local_len: RST_MAX_LOCAL_LEN,
		max_label_len: RST_MAX_LABEL_LEN,
		min_labels:    RST_MIN_LABELS
	};

	// ------------------------------------------------------------------------
	// Signals of the unit under test. Every input has a known value from time
	// zero on.
	// ------------------------------------------------------------------------
	logic                  clk       = 1'b0;
	logic                  arst_n    = 1'b0;
	logic                  in_valid  = 1'b0;
	logic                  in_ready;
	in_word_t              in_data   = '0;
	logic                  out_valid;
	logic                  out_ready = 1'b0;
	out_word_t             out_data;
	logic                  cfg_wr_en = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data  = '0;

	email_syntax_checker_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// ------------------------------------------------------------------------
	// Bench state: the expected verdicts in order, the byte list of the next
	// address to send, the register values the unit is believed to hold, and
	// the counters.
	// ------------------------------------------------------------------------
	out_word_t  pending_verdicts[$];
	logic [7:0] addr_buf[$];
	cfg_t       regs_model = DEFAULT_REGS;
	bit         steady_flow = 1'b0;
	int         words_sent = 0;
	int         mismatch_count = 0;
	out_word_t  verdict_want;

	// Per-address scan state of the prediction. Counters saturate at 255.
	logic [7:0] sc_total;
	logic       sc_total_over;
	logic       sc_seen_at;
	logic [7:0] sc_local_len;
	logic       sc_local_edge;
	logic [7:0] sc_prev;
	err_code_t  sc_local_err;
	err_code_t  sc_domain_err;
	logic [7:0] sc_label_len;
	logic       sc_label_hyph;
	logic       sc_label_bad;
	logic [7:0] sc_label_cnt;

	// ------------------------------------------------------------------------
	// Prediction of the verdicts.
	// ------------------------------------------------------------------------
	function automatic logic is_alnum_char(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	function automatic logic is_edge_char(input logic [7:0] c);
		return c == CHAR_DOT || c == CHAR_HYPHEN;
	endfunction

	function automatic logic [7:0] sat_inc(input logic [7:0] v);
		return (v == 8'hFF) ? v : v + 8'd1;
	endfunction

	task automatic clear_scan();
		sc_total      = '0;
		sc_total_over = 1'b0;
		sc_seen_at    = 1'b0;
		sc_local_len  = '0;
		sc_local_edge = 1'b0;
		sc_prev       = '0;
		sc_local_err  = ERR_NONE;
		sc_domain_err = ERR_NONE;
		sc_label_len  = '0;
		sc_label_hyph = 1'b0;
		sc_label_bad  = 1'b0;
		sc_label_cnt  = '0;
	endtask

	// Ends the current domain label. Only the first faulty label is kept,
	// and within it size goes before a hyphen at an edge, which goes before a
	// bad character.
	task automatic close_label(input logic [7:0] last_char);
		err_code_t err;
		err = ERR_NONE;
		if (sc_label_len == 0 || sc_label_len > regs_model.max_label_len) begin
			err = ERR_LABEL_SIZE;
		end else if (sc_label_hyph || last_char == CHAR_HYPHEN) begin
			err = ERR_LABEL_HYPHEN;
		end else if (sc_label_bad) begin
			err = ERR_DOMAIN_CHAR;
		end
		if (err != ERR_NONE && sc_domain_err == ERR_NONE) sc_domain_err = err;
		sc_label_cnt  = sat_inc(sc_label_cnt);
		sc_label_len  = '0;
		sc_label_hyph = 1'b0;
		sc_label_bad  = 1'b0;
	endtask

	// Updates the scan with one accepted byte and, on the final byte, queues
	// the verdict of the whole address.
	task automatic track_address_byte(input in_word_t w);
		logic [7:0] c;
		logic       in_domain;
		logic       at_now;
		err_code_t  code;
		out_word_t  verdict;
		c         = w.char_byte;
		in_domain = sc_seen_at;
		at_now    = 1'b0;
		code      = ERR_NONE;

		if (sc_total == 8'hFF) sc_total_over = 1'b1;
		else sc_total = sc_total + 8'd1;

		if (!in_domain) begin
			if (c == CHAR_AT) begin
				// The first at sign splits the address; a dot or hyphen just
				// before it ends the local part on an edge.
				sc_seen_at = 1'b1;
				at_now     = 1'b1;
				if (sc_local_len != 0 && is_edge_char(sc_prev)) sc_local_edge = 1'b1;
			end else begin
				if (sc_local_len == 0) begin
					if (is_edge_char(c)) sc_local_edge = 1'b1;
				end else if (is_edge_char(sc_prev) && !is_alnum_char(c) &&
						sc_local_err == ERR_NONE) begin
					sc_local_err = ERR_EDGE_FOLLOW;
				end
				if (!is_alnum_char(c) && !is_edge_char(c) && sc_local_err == ERR_NONE) begin
					sc_local_err = ERR_LOCAL_CHAR;
				end
				sc_local_len = sat_inc(sc_local_len);
			end
		end else if (c == CHAR_DOT) begin
			close_label(sc_prev);
		end else begin
			// A second at sign lands here and counts as a bad domain character.
			if (sc_label_len == 0) sc_label_hyph = (c == CHAR_HYPHEN);
			if (!is_alnum_char(c) && c != CHAR_HYPHEN) sc_label_bad = 1'b1;
			sc_label_len = sat_inc(sc_label_len);
		end
		sc_prev = c;

		if (w.is_last) begin
			// A single trailing dot has already closed the last label and does
			// not open another one.
			if (in_domain && c != CHAR_DOT) close_label(c);
			if (sc_total_over || sc_total > regs_model.max_total_len) begin
				code = ERR_LENGTH;
			end else if (!sc_seen_at || sc_local_len == 0 || at_now) begin
				code = ERR_FORM;
			end else if (sc_local_len > regs_model.max_local_len) begin
				code = ERR_LOCAL_LONG;
			end else if (sc_local_edge) begin
				code = ERR_LOCAL_EDGE;
			end else if (sc_local_err != ERR_NONE) begin
				code = sc_local_err;
			end else if (sc_domain_err != ERR_NONE) begin
				code = sc_domain_err;
			end else if (sc_label_cnt < regs_model.min_labels) begin
				code = ERR_FEW_LABELS;
			end
			verdict.address_ok = (code == ERR_NONE);
			verdict.error_code = code;
			pending_verdicts.push_back(verdict);
			clear_scan();
		end
	endtask

	// ------------------------------------------------------------------------
	// Monitors. Both sample at the rising edge, where the bench's own drives
	// still hold their pre-edge values.
	// ------------------------------------------------------------------------
	task automatic report_mismatch(input string msg);
		mismatch_count++;
		if (mismatch_count <= MAX_PRINTS) $display("MISMATCH @%0t ns: %s", $time, msg);
	endtask

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready) track_address_byte(in_data);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_verdicts.size() == 0) begin
				report_mismatch($sformatf("verdict ok=%0d code=%0d with none expected",
					out_data.address_ok, out_data.error_code));
			end else begin
				verdict_want = pending_verdicts.pop_front();
				if (out_data.address_ok !== verdict_want.address_ok) begin
					report_mismatch($sformatf("address_ok %0b, expected %0b",
						out_data.address_ok, verdict_want.address_ok));
				end
				if (out_data.error_code !== verdict_want.error_code) begin
					report_mismatch($sformatf("error_code %0d, expected %0d",
						out_data.error_code, verdict_want.error_code));
				end
			end
		end
	end

	// The receiver stalls at random, except during the steady stretch.
	always @(posedge clk) begin
		if (!steady_flow && $urandom_range(99) < IDLE_PERCENT) out_ready <= 1'b0;
		else out_ready <= 1'b1;
	end

	// ------------------------------------------------------------------------
	// Sending. send_word leaves valid high after its word is taken, so the
	// next word or an idle cycle replaces it with a single assignment.
	// ------------------------------------------------------------------------
	task automatic send_word(input logic [7:0] c, input logic last);
		while (!steady_flow && $urandom_range(99) < IDLE_PERCENT) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid          <= 1'b1;
		in_data.char_byte <= c;
		in_data.is_last   <= last;
		do @(posedge clk); while (!in_ready);
		words_sent++;
	endtask

	task automatic send_buffer();
		for (int i = 0; i < addr_buf.size(); i++) begin
			send_word(addr_buf[i], i == addr_buf.size() - 1);
		end
		addr_buf = {};
	endtask

	task automatic append_text(input string s);
		for (int i = 0; i < s.len(); i++) addr_buf.push_back(s[i]);
	endtask

	task automatic send_text(input string s);
		addr_buf = {};
		append_text(s);
		send_buffer();
	endtask

	// Holds the sender until every expected verdict is out and the pipeline
	// has had time to empty behind it.
	task automatic wait_for_verdicts();
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_verdicts.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
	endtask

	// Registers only change while the unit is idle, so the predictor can take
	// the new values at once.
	task automatic load_config(input cfg_t c);
		wait_for_verdicts();
		write_reg(REG_MAX_TOTAL_LEN, c.max_total_len);
		write_reg(REG_MAX_LOCAL_LEN, c.max_local_len);
		write_reg(REG_MAX_LABEL_LEN, c.max_label_len);
		write_reg(REG_MIN_LABELS, {4'd0, c.min_labels});
		cfg_wr_en  <= 1'b0;
		regs_model = c;
	endtask

	// ------------------------------------------------------------------------
	// Address generators.
	// ------------------------------------------------------------------------
	function automatic logic [7:0] pick_alnum();
		return ALNUM_SET[$urandom_range(ALNUM_SET.len() - 1)];
	endfunction

	function automatic logic [7:0] pick_local_char();
		int r;
		r = $urandom_range(99);
		if (r < 80) return pick_alnum();
		else if (r < 88) return CHAR_DOT;
		else if (r < 95) return CHAR_HYPHEN;
		else return 8'($urandom_range(255));
	endfunction

	function automatic logic [7:0] pick_domain_char();
		int r;
		r = $urandom_range(99);
		if (r < 84) return pick_alnum();
		else if (r < 94) return CHAR_HYPHEN;
		else return 8'($urandom_range(255));
	endfunction

	// Alphanumeric local part, then labels of equal length joined by dots.
	task automatic append_long_address(input int local_n, input int label_n,
			input int labels);
		repeat (local_n) addr_buf.push_back(pick_alnum());
		addr_buf.push_back(CHAR_AT);
		for (int i = 0; i < labels; i++) begin
			if (i != 0) addr_buf.push_back(CHAR_DOT);
			repeat (label_n) addr_buf.push_back(pick_alnum());
		end
	endtask

	// Mostly address-shaped byte lists with random content; some are pure
	// noise, some lose their at sign or local part, some are cut short.
	task automatic build_random_address();
		int n;
		int labels;
		int len;
		addr_buf = {};
		if ($urandom_range(99) < 12) begin
			n = $urandom_range(1, 6);
			repeat (n) addr_buf.push_back(8'($urandom_range(255)));
			return;
		end
		n = ($urandom_range(99) < 4) ? 0 : $urandom_range(1, 8);
		repeat (n) addr_buf.push_back(pick_local_char());
		if ($urandom_range(99) >= 4) addr_buf.push_back(CHAR_AT);
		labels = $urandom_range(1, 4);
		for (int i = 0; i < labels; i++) begin
			if (i != 0) addr_buf.push_back(CHAR_DOT);
			len = ($urandom_range(99) < 5) ? 0 : $urandom_range(1, 7);
			repeat (len) addr_buf.push_back(pick_domain_char());
		end
		if ($urandom_range(99) < 8) addr_buf.push_back(CHAR_DOT);
		if ($urandom_range(99) < 6 && addr_buf.size() > 1) begin
			n = $urandom_range(1, addr_buf.size() - 1);
			while (addr_buf.size() > n) void'(addr_buf.pop_back());
		end
		if (addr_buf.size() == 0) addr_buf.push_back(pick_alnum());
	endtask

	// Small limits make every size rule reachable with short addresses; the
	// largest values show up now and then.
	function automatic cfg_t random_config();
		cfg_t c;
		c.max_total_len = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(4, 40));
		c.max_local_len = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(1, 10));
		c.max_label_len = ($urandom_range(3) == 0) ? 8'd255 : 8'($urandom_range(1, 8));
		c.min_labels    = 4'($urandom_range(0, 5));
		return c;
	endfunction

	// ------------------------------------------------------------------------
	// Tests.
	// ------------------------------------------------------------------------

	// One short address per syntax rule under the reset limits.
	task automatic test_syntax_rules();
		load_config(DEFAULT_REGS);
		send_text("a@b.c");
		send_text("A-z.9@x-Y.Z0");
		send_text("abc");
		send_text("@b.c");
		send_text("a@");
		send_text("a@b@c.d");
		send_text("a@.b");
		send_text("a@b..c");
		send_text("a@b.c.");
		send_text("-a@b.c");
		send_text("a.@b.c");
		send_text("a..b@c.d");
		send_text("a+b@c.d");
		send_text("a@-b.c");
		send_text("a@b-.c");
		send_text("a@b_c.d");
		send_text("a@b");
		send_text(".");
		// Bytes at both ends of the range: one in the local part, one in a
		// label.
		addr_buf = {};
		addr_buf.push_back(8'hFF);
		append_text("@b.c");
		send_buffer();
		addr_buf = {};
		append_text("a@b");
		addr_buf.push_back(8'h00);
		append_text(".c");
		send_buffer();
	endtask

	// Register corners, from zero up to the largest values each register holds.
	task automatic test_register_limits();
		load_config('{max_total_len: 8'd0, max_local_len: 8'd255,
			max_label_len: 8'd255, min_labels: 4'd0});
		send_text("a@b");
		load_config('{max_total_len: 8'd255, max_local_len: 8'd255,
			max_label_len: 8'd255, min_labels: 4'd0});
		send_text("a@b");
		send_text("a@b.");
		load_config('{max_total_len: 8'd255, max_local_len: 8'd1,
			max_label_len: 8'd1, min_labels: 4'd8});
		send_text("ab@c.d");
		send_text("a@bc.d");
		send_text("a@b.c.d.e.f.g.h.i");
		send_text("a@b.c.d.e.f.g.h");
		load_config('{max_total_len: 8'd1, max_local_len: 8'd0,
			max_label_len: 8'd0, min_labels: 4'd15});
		send_text("a");
		load_config('{max_total_len: 8'd255, max_local_len: 8'd0,
			max_label_len: 8'd0, min_labels: 4'd15});
		send_text("a@b.c");
		load_config('{max_total_len: 8'd255, max_local_len: 8'd5,
			max_label_len: 8'd5, min_labels: 4'd15});
		send_text("a@b.c");
	endtask

	// Local part and label at their reset limits, and an address beyond the
	// width of the counters.
	task automatic test_long_addresses();
		load_config(DEFAULT_REGS);
		addr_buf = {}; append_long_address(64, 63, 2); send_buffer();
		load_config('{max_total_len: 8'd255, max_local_len: 8'd255,
			max_label_len: 8'd255, min_labels: RST_MIN_LABELS});
		// A local part past 255 bytes with no at sign saturates its counter.
		addr_buf = {};
		repeat (260) addr_buf.push_back(pick_alnum());
		send_buffer();
	endtask

	// Random addresses in phases, each under its own register setting. One
	// phase runs with no stalls on either side, and now and then the sender
	// holds until every verdict is out.
	task automatic test_random_traffic();
		int phase_end;
		for (int phase = 0; phase < 6; phase++) begin
			load_config(random_config());
			steady_flow = (phase == 2);
			phase_end = words_sent + RANDOM_WORDS / 6;
			while (words_sent < phase_end) begin
				build_random_address();
				send_buffer();
				if ($urandom_range(99) < 3) wait_for_verdicts();
			end
		end
		steady_flow = 1'b0;
	endtask

	// ------------------------------------------------------------------------
	// Main sequence.
	// ------------------------------------------------------------------------
	initial begin
		int settle;
		clear_scan();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		test_syntax_rules();
		test_register_limits();
		test_long_addresses();
		test_random_traffic();

		in_valid <= 1'b0;
		settle = 0;
		while (pending_verdicts.size() != 0 && settle < SETTLE_LIMIT) begin
			@(posedge clk);
			settle++;
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_verdicts.size() != 0) begin
			report_mismatch($sformatf("%0d verdicts never arrived", pending_verdicts.size()));
		end

		if (mismatch_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

	// Hard stop in case the handshake hangs.
	initial begin
		#(TIMEOUT_NS);
		$display("== FAIL ==");
		$finish;
	end

endmodule
